### rtl/core/latency_histogram_percentile_macros.svh
// ----------------------------------------------------------------------------
// latency_histogram_percentile_macros.svh
// Assertion macros used by the histogram checker.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_PERCENTILE_MACROS_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define LHP_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, off while reset is held.
`define LHP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

### rtl/core/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg
// Types, constants and helpers for the decade latency histogram.
// ----------------------------------------------------------------------------
package lhp_pkg;

    localparam int COUNTER_BITS = 40;
    localparam int NUM_BUCKETS  = 7;
    localparam int NUM_LIMITS   = NUM_BUCKETS - 1;
    localparam int BUCKET_W     = 3;
    localparam int SAMPLE_W     = 32;
    localparam int SUM_W        = 64;
    localparam int FRAC_W       = 16;
    localparam int NUM_PCT      = 3;
    localparam int CUM_W        = COUNTER_BITS + BUCKET_W;
    localparam int PROD_W       = COUNTER_BITS + FRAC_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNTER_BITS-1:0] COUNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [SUM_W-1:0]        SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SAMPLE_W-1:0]     MIN_INIT  = {SAMPLE_W{1'b1}};

    localparam logic [SAMPLE_W-1:0] DECADE_LIMIT [NUM_LIMITS] = '{
        32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000, 32'd10000000
    };

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT_HIGH = 2'd2;

    localparam logic [FRAC_W-1:0] PCT_LOW_RESET  = 16'd32768;
    localparam logic [FRAC_W-1:0] PCT_MID_RESET  = 16'd62259;
    localparam logic [FRAC_W-1:0] PCT_HIGH_RESET = 16'd64881;

    typedef enum logic {
        REQ_RECORD = 1'b0,
        REQ_CLEAR  = 1'b1
    } req_t;

    typedef struct packed {
        req_t                  req;
        logic [SAMPLE_W-1:0]   sample;
        logic [BUCKET_W-1:0]   bucket;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [COUNTER_BITS-1:0] total;
        logic [SUM_W-1:0]        sum;
        logic [SAMPLE_W-1:0]     least;
        logic [SAMPLE_W-1:0]     greatest;
        logic [BUCKET_W-1:0]     hit;
        logic [COUNTER_BITS-1:0] hit_total;
    } stats_t;

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [SAMPLE_W-1:0] v);
        logic [BUCKET_W-1:0] b;
        b = BUCKET_W'(NUM_BUCKETS - 1);
        for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
            if (v < DECADE_LIMIT[i]) begin
                b = BUCKET_W'(i);
            end
        end
        return b;
    endfunction

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

### rtl/core/lhp_queue.sv
// ----------------------------------------------------------------------------
// lhp_queue
// Short FIFO between the classifying front end and the statistics back end.
// ----------------------------------------------------------------------------
module lhp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lhp_pkg::item_t    push_item,
    input  logic              pop,
    output lhp_pkg::item_t    head_item,
    output lhp_pkg::q_status_t status
);

    lhp_pkg::item_t                    mem_reg [lhp_pkg::QUEUE_DEPTH];
    logic [lhp_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [lhp_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [lhp_pkg::QCNT_W-1:0]        count_reg, count_next;

    localparam logic [lhp_pkg::QPTR_W-1:0] LAST_PTR = lhp_pkg::QPTR_W'(lhp_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == lhp_pkg::QCNT_W'(lhp_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### rtl/core/lhp_front.sv
// ----------------------------------------------------------------------------
// lhp_front
// Accepts request transactions and tags each sample with its decade bucket.
// ----------------------------------------------------------------------------
module lhp_front (
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [lhp_pkg::SAMPLE_W-1:0]   s_sample_value,
    input  lhp_pkg::q_status_t             q_status,
    output logic                           push,
    output lhp_pkg::item_t                 push_item
);

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_item.req    = lhp_pkg::req_t'(s_req_type);
        push_item.sample = s_sample_value;
        push_item.bucket = lhp_pkg::bucket_of(s_sample_value);
    end

endmodule

### rtl/core/lhp_back.sv
// ----------------------------------------------------------------------------
// lhp_back
// Updates the histogram store and resolves the three percentile buckets.
// ----------------------------------------------------------------------------
module lhp_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lhp_pkg::q_status_t                 q_status,
    input  lhp_pkg::item_t                     head_item,
    output logic                               pop,
    input  logic [lhp_pkg::FRAC_W-1:0]         pct_frac [lhp_pkg::NUM_PCT],
    output logic                               m_valid,
    input  logic                               m_ready,
    output lhp_pkg::stats_t                    m_stats,
    output logic [lhp_pkg::BUCKET_W-1:0]       m_pct [lhp_pkg::NUM_PCT]
);

    localparam int CB = lhp_pkg::COUNTER_BITS;
    localparam int NB = lhp_pkg::NUM_BUCKETS;
    localparam int NP = lhp_pkg::NUM_PCT;

    // histogram store
    logic [CB-1:0]                  bucket_reg [NB];
    logic [CB-1:0]                  bucket_next [NB];
    logic [CB-1:0]                  total_reg, total_next;
    logic [lhp_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [lhp_pkg::SAMPLE_W-1:0]   min_reg, min_next;
    logic [lhp_pkg::SAMPLE_W-1:0]   max_reg, max_next;
    logic [lhp_pkg::SUM_W:0]        sum_wide;
    logic [lhp_pkg::BUCKET_W-1:0]   hit;
    logic [CB-1:0]                  hit_total;

    // pipeline stages
    logic                           advance;
    logic                           s1_valid_reg;
    lhp_pkg::stats_t                s1_stats_reg;
    logic [CB-1:0]                  s1_bucket_reg [NB];
    logic                           s2_valid_reg;
    lhp_pkg::stats_t                s2_stats_reg;
    logic [CB-1:0]                  s2_target_reg [NP];
    logic [lhp_pkg::CUM_W-1:0]      s2_cum_reg [NB];
    logic [lhp_pkg::PROD_W-1:0]     prod [NP];
    logic [lhp_pkg::CUM_W-1:0]      cum [NB];
    logic [lhp_pkg::BUCKET_W-1:0]   pct_sel [NP];
    logic                           out_valid_reg;
    lhp_pkg::stats_t                out_stats_reg;
    logic [lhp_pkg::BUCKET_W-1:0]   out_pct_reg [NP];

    assign advance = !out_valid_reg || m_ready;
    assign pop     = advance && !q_status.empty;

    // store update for the item at the queue head
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            bucket_next[i] = bucket_reg[i];
        end
        total_next = total_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        hit        = '0;
        hit_total  = '0;
        sum_wide   = {1'b0, sum_reg} + (lhp_pkg::SUM_W + 1)'(head_item.sample);
        if (head_item.req == lhp_pkg::REQ_CLEAR) begin
            for (int i = 0; i < NB; i++) begin
                bucket_next[i] = '0;
            end
            total_next = '0;
            sum_next   = '0;
            min_next   = lhp_pkg::MIN_INIT;
            max_next   = '0;
        end else begin
            total_next = lhp_pkg::sat_inc(total_reg);
            sum_next   = sum_wide[lhp_pkg::SUM_W] ? lhp_pkg::SUM_MAX
                                                  : sum_wide[lhp_pkg::SUM_W-1:0];
            if (head_item.sample < min_reg) begin
                min_next = head_item.sample;
            end
            if (head_item.sample > max_reg) begin
                max_next = head_item.sample;
            end
            hit       = head_item.bucket;
            hit_total = lhp_pkg::sat_inc(bucket_reg[head_item.bucket]);
            bucket_next[head_item.bucket] = hit_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NB; i++) begin
                bucket_reg[i] <= '0;
            end
            total_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= lhp_pkg::MIN_INIT;
            max_reg   <= '0;
        end else if (pop) begin
            for (int i = 0; i < NB; i++) begin
                bucket_reg[i] <= bucket_next[i];
            end
            total_reg <= total_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    // targets and cumulative counts from the stage 1 snapshot
    always_comb begin
        for (int p = 0; p < NP; p++) begin
            prod[p] = {{lhp_pkg::FRAC_W{1'b0}}, s1_stats_reg.total}
                    * {{CB{1'b0}}, pct_frac[p]};
        end
        cum[0] = lhp_pkg::CUM_W'(s1_bucket_reg[0]);
        for (int i = 1; i < NB; i++) begin
            cum[i] = cum[i-1] + lhp_pkg::CUM_W'(s1_bucket_reg[i]);
        end
    end

    // first bucket whose running count reaches the target, else last; 0 if empty
    always_comb begin
        for (int p = 0; p < NP; p++) begin
            pct_sel[p] = lhp_pkg::BUCKET_W'(NB - 1);
            for (int i = NB - 1; i >= 0; i--) begin
                if (s2_cum_reg[i] >= lhp_pkg::CUM_W'(s2_target_reg[p])) begin
                    pct_sel[p] = lhp_pkg::BUCKET_W'(i);
                end
            end
            if (s2_stats_reg.total == '0) begin
                pct_sel[p] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_stats_reg.total     <= total_next;
            s1_stats_reg.sum       <= sum_next;
            s1_stats_reg.least     <= (total_next == '0) ? '0 : min_next;
            s1_stats_reg.greatest  <= max_next;
            s1_stats_reg.hit       <= hit;
            s1_stats_reg.hit_total <= hit_total;
            for (int i = 0; i < NB; i++) begin
                s1_bucket_reg[i] <= bucket_next[i];
                s2_cum_reg[i]    <= cum[i];
            end
            s2_stats_reg <= s1_stats_reg;
            for (int p = 0; p < NP; p++) begin
                s2_target_reg[p] <= prod[p][lhp_pkg::PROD_W-1:lhp_pkg::FRAC_W];
                out_pct_reg[p]   <= pct_sel[p];
            end
            out_stats_reg <= s2_stats_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_stats = out_stats_reg;
    assign m_pct   = out_pct_reg;

endmodule

### rtl/core/latency_histogram_percentile.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentile
// Decade latency histogram with count, sum, min, max and three percentiles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): s_req_type 0 records s_sample_value (us),
//   1 clears the store. Every input transaction yields exactly one result
//   transaction on the m_ channel, in order.
//   Results carry the statistics after the update, the sample's bucket and its
//   count, and the buckets that reach the three percentile fractions.
//   Configuration: cfg_wr_en with cfg_index 0..2 writes the Q0.16 fractions;
//   index 3 is ignored. Write only while no transaction is in flight.
//   An accepted input waits in the queue, then passes stage 1, stage 2 and
//   output registers. Throughput: one transaction per cycle unless m_ready
//   stalls; the store updates on pop, the percentile search in two stages.
//   A two-entry queue separates the classifying front end from the back end.
//   When m_ready is low the back-end pipeline holds; the queue still takes
//   transactions until it fills, then s_ready drops.
//   Reset (aresetn low, synchronous) empties the store and the pipeline and
//   loads the fractions 0.5, 0.95 and 0.99.
// ----------------------------------------------------------------------------
module latency_histogram_percentile (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic [lhp_pkg::SAMPLE_W-1:0]         s_sample_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lhp_pkg::COUNTER_BITS-1:0]     m_total_samples,
    output logic [lhp_pkg::SUM_W-1:0]            m_running_sum,
    output logic [lhp_pkg::SAMPLE_W-1:0]         m_least_sample,
    output logic [lhp_pkg::SAMPLE_W-1:0]         m_greatest_sample,
    output logic [lhp_pkg::BUCKET_W-1:0]         m_hit_bucket,
    output logic [lhp_pkg::COUNTER_BITS-1:0]     m_hit_bucket_total,
    output logic [lhp_pkg::BUCKET_W-1:0]         m_pct_low_bucket,
    output logic [lhp_pkg::BUCKET_W-1:0]         m_pct_mid_bucket,
    output logic [lhp_pkg::BUCKET_W-1:0]         m_pct_high_bucket,
    input  logic                                 cfg_wr_en,
    input  logic [lhp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lhp_pkg::FRAC_W-1:0]           cfg_wdata
);

    logic [lhp_pkg::FRAC_W-1:0]   pct_frac_reg [lhp_pkg::NUM_PCT];
    logic                         push;
    logic                         pop;
    lhp_pkg::item_t               push_item;
    lhp_pkg::item_t               head_item;
    lhp_pkg::q_status_t           q_status;
    lhp_pkg::stats_t              m_stats;
    logic [lhp_pkg::BUCKET_W-1:0] m_pct [lhp_pkg::NUM_PCT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_frac_reg[0] <= lhp_pkg::PCT_LOW_RESET;
            pct_frac_reg[1] <= lhp_pkg::PCT_MID_RESET;
            pct_frac_reg[2] <= lhp_pkg::PCT_HIGH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lhp_pkg::CFG_PCT_LOW:  pct_frac_reg[0] <= cfg_wdata;
                lhp_pkg::CFG_PCT_MID:  pct_frac_reg[1] <= cfg_wdata;
                lhp_pkg::CFG_PCT_HIGH: pct_frac_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lhp_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_sample_value (s_sample_value),
        .q_status       (q_status),
        .push           (push),
        .push_item      (push_item)
    );

    lhp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    lhp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .pct_frac  (pct_frac_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_stats   (m_stats),
        .m_pct     (m_pct)
    );

    assign m_total_samples    = m_stats.total;
    assign m_running_sum      = m_stats.sum;
    assign m_least_sample     = m_stats.least;
    assign m_greatest_sample  = m_stats.greatest;
    assign m_hit_bucket       = m_stats.hit;
    assign m_hit_bucket_total = m_stats.hit_total;
    assign m_pct_low_bucket   = m_pct[0];
    assign m_pct_mid_bucket   = m_pct[1];
    assign m_pct_high_bucket  = m_pct[2];

endmodule

### rtl/core/lhp_checker.sv
// ----------------------------------------------------------------------------
// lhp_checker
// Port-level checks on the result channel of the latency histogram.
// ----------------------------------------------------------------------------
`include "latency_histogram_percentile_macros.svh"

module lhp_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [lhp_pkg::COUNTER_BITS-1:0]     m_total_samples,
    input logic [lhp_pkg::SAMPLE_W-1:0]         m_least_sample,
    input logic [lhp_pkg::SAMPLE_W-1:0]         m_greatest_sample,
    input logic [lhp_pkg::BUCKET_W-1:0]         m_hit_bucket,
    input logic [lhp_pkg::COUNTER_BITS-1:0]     m_hit_bucket_total,
    input logic [lhp_pkg::BUCKET_W-1:0]         m_pct_low_bucket,
    input logic [lhp_pkg::BUCKET_W-1:0]         m_pct_mid_bucket,
    input logic [lhp_pkg::BUCKET_W-1:0]         m_pct_high_bucket
);

    // a stalled result stays up
    `LHP_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready, m_valid)

    // an empty store reports zero minimum and bucket 0 for every percentile
    `LHP_ASSERT_IMPLIES(a_empty_zero, aclk, aresetn, m_valid && m_total_samples == '0, m_least_sample == '0 && m_pct_low_bucket == '0 && m_pct_mid_bucket == '0 && m_pct_high_bucket == '0)

    // minimum never exceeds maximum once anything is recorded
    `LHP_ASSERT_IMPLIES(a_min_le_max, aclk, aresetn, m_valid && m_total_samples != '0, m_least_sample <= m_greatest_sample)

    // a bucket never holds more than the store; zero hit count implies bucket 0
    `LHP_ASSERT_IMPLIES(a_hit_le_total, aclk, aresetn, m_valid, m_hit_bucket_total <= m_total_samples && (m_hit_bucket_total != '0 || m_hit_bucket == '0))

endmodule

bind latency_histogram_percentile lhp_checker u_lhp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_total_samples    (m_total_samples),
    .m_least_sample     (m_least_sample),
    .m_greatest_sample  (m_greatest_sample),
    .m_hit_bucket       (m_hit_bucket),
    .m_hit_bucket_total (m_hit_bucket_total),
    .m_pct_low_bucket   (m_pct_low_bucket),
    .m_pct_mid_bucket   (m_pct_mid_bucket),
    .m_pct_high_bucket  (m_pct_high_bucket)
);

### sim/lhp_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhp_stats_checker
// Watches both channels and the register port of the latency histogram. It
// keeps its own copy of the histogram, computes the statistics and the
// percentile buckets that each input transaction should produce, and compares
// every result transaction with them, field by field and in order.
// ----------------------------------------------------------------------------
module lhp_stats_checker
    import lhp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [SAMPLE_W-1:0]     s_sample_value,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [COUNTER_BITS-1:0] m_total_samples,
    input  logic [SUM_W-1:0]        m_running_sum,
    input  logic [SAMPLE_W-1:0]     m_least_sample,
    input  logic [SAMPLE_W-1:0]     m_greatest_sample,
    input  logic [BUCKET_W-1:0]     m_hit_bucket,
    input  logic [COUNTER_BITS-1:0] m_hit_bucket_total,
    input  logic [BUCKET_W-1:0]     m_pct_low_bucket,
    input  logic [BUCKET_W-1:0]     m_pct_mid_bucket,
    input  logic [BUCKET_W-1:0]     m_pct_high_bucket,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [FRAC_W-1:0]       cfg_wdata,
    output int                      miss_count,
    output int                      pending
);

    localparam logic [SAMPLE_W-1:0] DECADE_EDGE [6] = '{
        32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000, 32'd10000000
    };
    localparam logic [BUCKET_W-1:0] OVERFLOW_BUCKET = 3'd6;
    localparam int                  DUE_DEPTH       = 16;

    typedef struct packed {
        logic [COUNTER_BITS-1:0] total;
        logic [SUM_W-1:0]        sum;
        logic [SAMPLE_W-1:0]     least;
        logic [SAMPLE_W-1:0]     greatest;
        logic [BUCKET_W-1:0]     hit;
        logic [COUNTER_BITS-1:0] hit_total;
        logic [BUCKET_W-1:0]     pct_low;
        logic [BUCKET_W-1:0]     pct_mid;
        logic [BUCKET_W-1:0]     pct_high;
    } stats_snapshot_t;

    logic [COUNTER_BITS-1:0] bucket_count [7];
    logic [COUNTER_BITS-1:0] seen_count;
    logic [SUM_W-1:0]        seen_sum;
    logic [SAMPLE_W-1:0]     seen_min;
    logic [SAMPLE_W-1:0]     seen_max;
    logic [FRAC_W-1:0]       pct_frac [3];

    // expected results in input order, read at due_rd and written at due_wr
    stats_snapshot_t stats_due [DUE_DEPTH];
    int              due_wr;
    int              due_rd;

    initial begin
        miss_count = 0;
        pending    = 0;
        due_wr     = 0;
        due_rd     = 0;
    end

    function automatic logic [COUNTER_BITS-1:0] bump(input logic [COUNTER_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_store();
        for (int i = 0; i < 7; i++) bucket_count[i] = '0;
        seen_count = '0;
        seen_sum   = '0;
        seen_min   = '1;
        seen_max   = '0;
    endfunction

    // First bucket whose running count reaches floor(count * frac / 2^16).
    function automatic logic [BUCKET_W-1:0] pct_bucket_for(input logic [FRAC_W-1:0] frac);
        logic [55:0]             prod;
        logic [COUNTER_BITS-1:0] goal;
        logic [47:0]             cum;
        logic [BUCKET_W-1:0]     pick;
        bit                      found;
        if (seen_count == '0) return '0;
        prod  = 56'(seen_count) * 56'(frac);
        goal  = prod[55:16];
        cum   = '0;
        pick  = OVERFLOW_BUCKET;
        found = 0;
        for (int i = 0; i < 7; i++) begin
            cum = cum + 48'(bucket_count[i]);
            if (!found && cum >= 48'(goal)) begin
                pick  = BUCKET_W'(i);
                found = 1;
            end
        end
        return pick;
    endfunction

    function automatic stats_snapshot_t tally_request(input req_t req,
                                                      input logic [SAMPLE_W-1:0] v);
        stats_snapshot_t  r;
        logic [SUM_W:0]   wide_sum;
        int               b;
        r = '0;
        if (req == REQ_CLEAR) begin
            clear_store();
        end else begin
            b = 6;
            for (int i = 5; i >= 0; i--) begin
                if (v < DECADE_EDGE[i]) b = i;
            end
            seen_count      = bump(seen_count);
            bucket_count[b] = bump(bucket_count[b]);
            wide_sum        = {1'b0, seen_sum} + (SUM_W + 1)'(v);
            seen_sum        = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
            if (v < seen_min) seen_min = v;
            if (v > seen_max) seen_max = v;
            r.hit       = BUCKET_W'(b);
            r.hit_total = bucket_count[b];
        end
        r.total    = seen_count;
        r.sum      = seen_sum;
        r.least    = (seen_count == '0) ? '0 : seen_min;
        r.greatest = seen_max;
        r.pct_low  = pct_bucket_for(pct_frac[0]);
        r.pct_mid  = pct_bucket_for(pct_frac[1]);
        r.pct_high = pct_bucket_for(pct_frac[2]);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            miss_count++;
            if (miss_count <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        stats_snapshot_t want;
        if (!aresetn) begin
            clear_store();
            pct_frac[0] = PCT_LOW_RESET;
            pct_frac[1] = PCT_MID_RESET;
            pct_frac[2] = PCT_HIGH_RESET;
            due_wr      = 0;
            due_rd      = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PCT_LOW:  pct_frac[0] = cfg_wdata;
                    CFG_PCT_MID:  pct_frac[1] = cfg_wdata;
                    CFG_PCT_HIGH: pct_frac[2] = cfg_wdata;
                    default: ;  // spare index: drop the write
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_wr == due_rd) begin
                    miss_count++;
                    if (miss_count <= 10)
                        $display("%0t: result transaction with nothing expected", $time);
                end else begin
                    want   = stats_due[due_rd % DUE_DEPTH];
                    due_rd = due_rd + 1;
                    check_field("total_samples", 64'(m_total_samples), 64'(want.total));
                    check_field("running_sum", m_running_sum, want.sum);
                    check_field("least_sample", 64'(m_least_sample), 64'(want.least));
                    check_field("greatest_sample", 64'(m_greatest_sample),
                                64'(want.greatest));
                    check_field("hit_bucket", 64'(m_hit_bucket), 64'(want.hit));
                    check_field("hit_bucket_total", 64'(m_hit_bucket_total),
                                64'(want.hit_total));
                    check_field("pct_low_bucket", 64'(m_pct_low_bucket), 64'(want.pct_low));
                    check_field("pct_mid_bucket", 64'(m_pct_mid_bucket), 64'(want.pct_mid));
                    check_field("pct_high_bucket", 64'(m_pct_high_bucket),
                                64'(want.pct_high));
                end
            end
            if (s_valid && s_ready) begin
                if (due_wr - due_rd >= DUE_DEPTH) begin
                    miss_count++;
                    if (miss_count <= 10)
                        $display("%0t: too many transactions in flight", $time);
                end
                stats_due[due_wr % DUE_DEPTH] = tally_request(req_t'(s_req_type),
                                                              s_sample_value);
                due_wr = due_wr + 1;
            end
        end
        pending = due_wr - due_rd;
    end

endmodule

### sim/tb_latency_histogram_percentile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latency_histogram_percentile
// Drives record and clear transactions into the latency histogram under
// random source gaps and sink stalls, steps the percentile fractions through
// several settings between phases, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_latency_histogram_percentile;
    import lhp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 240;
    localparam int IDLE_LIMIT  = 2000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_req_type;
    logic [SAMPLE_W-1:0]     s_sample_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [COUNTER_BITS-1:0] m_total_samples;
    logic [SUM_W-1:0]        m_running_sum;
    logic [SAMPLE_W-1:0]     m_least_sample;
    logic [SAMPLE_W-1:0]     m_greatest_sample;
    logic [BUCKET_W-1:0]     m_hit_bucket;
    logic [COUNTER_BITS-1:0] m_hit_bucket_total;
    logic [BUCKET_W-1:0]     m_pct_low_bucket;
    logic [BUCKET_W-1:0]     m_pct_mid_bucket;
    logic [BUCKET_W-1:0]     m_pct_high_bucket;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [FRAC_W-1:0]       cfg_wdata;

    int miss_count;
    int pending;
    int idle_cycles;
    bit feed_burst;
    bit drain_burst;

    latency_histogram_percentile dut (.*);

    lhp_stats_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb_latency_histogram_percentile NOT OK");
        $finish;
    end

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int                  k;
        logic [SAMPLE_W-1:0] lo_edge;
        logic [SAMPLE_W-1:0] hi_edge;
        k = $urandom_range(0, 8);
        if (k == 8) return $urandom;
        if (k == 7) return DECADE_LIMIT[$urandom_range(0, 5)] - $urandom_range(0, 1);
        lo_edge = (k == 0) ? '0 : DECADE_LIMIT[k-1];
        hi_edge = (k == 6) ? '1 : DECADE_LIMIT[k] - 1;
        return $urandom_range(hi_edge, lo_edge);
    endfunction

    // Entered at a falling edge or just after an accepting rising edge.
    task automatic send_request(input req_t req, input logic [SAMPLE_W-1:0] v);
        int gap;
        gap = draw_gap(feed_burst);
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_sample_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every transaction has come back out.
    task automatic settle();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAC_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic load_fractions(input logic [FRAC_W-1:0] lo, input logic [FRAC_W-1:0] mid,
                                  input logic [FRAC_W-1:0] hi);
        write_cfg(CFG_PCT_LOW, lo);
        write_cfg(CFG_PCT_MID, mid);
        write_cfg(CFG_PCT_HIGH, hi);
        if ($urandom_range(0, 1)) write_cfg(CFG_IDX_SPARE, $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: stall for a drawn number of cycles, then take one transaction.
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            stall = draw_gap(drain_burst);
            if (stall > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        logic [FRAC_W-1:0] lo, mid, hi;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = REQ_RECORD;
        s_sample_value = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_PCT_LOW;
        cfg_wdata      = '0;
        feed_burst     = 1'b0;
        drain_burst    = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Decade edges under the reset fractions, then clears on full and empty store.
        send_request(REQ_RECORD, 32'd0);
        send_request(REQ_RECORD, 32'd99);
        send_request(REQ_RECORD, 32'd100);
        send_request(REQ_RECORD, 32'd999);
        send_request(REQ_RECORD, 32'd1000);
        send_request(REQ_RECORD, 32'd9999);
        send_request(REQ_RECORD, 32'd10000);
        send_request(REQ_RECORD, 32'd99999);
        send_request(REQ_RECORD, 32'd100000);
        send_request(REQ_RECORD, 32'd999999);
        send_request(REQ_RECORD, 32'd1000000);
        send_request(REQ_RECORD, 32'd9999999);
        send_request(REQ_RECORD, 32'd10000000);
        send_request(REQ_RECORD, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 32'd0);
        send_request(REQ_RECORD, 32'd5);

        // Zero fraction, full fraction and the smallest nonzero one.
        settle();
        load_fractions(16'd0, 16'hFFFF, 16'd1);
        send_request(REQ_RECORD, 32'd250);
        send_request(REQ_RECORD, 32'd7);
        send_request(REQ_RECORD, 32'd5000000);
        send_request(REQ_CLEAR, 32'd12345);
        send_request(REQ_RECORD, 32'd1);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin lo = 16'd0;    mid = 16'hFFFF; hi = 16'h8000; end
                1: begin lo = 16'hFFFF; mid = 16'hFFFF; hi = 16'hFFFF; end
                2: begin lo = 16'd0;    mid = 16'd0;    hi = 16'd0;    end
                3: begin lo = 16'd1;    mid = 16'h8000; hi = 16'hFFFE; end
                default: begin
                    lo  = $urandom;
                    mid = $urandom;
                    hi  = $urandom;
                end
            endcase
            load_fractions(lo, mid, hi);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 60 == 0) begin
                    feed_burst  = ($urandom_range(0, 3) == 0);
                    drain_burst = ($urandom_range(0, 3) == 0);
                end
                send_request(($urandom_range(0, 59) == 0) ? REQ_CLEAR : REQ_RECORD,
                             draw_sample());
            end
        end

        settle();
        repeat (8) @(negedge aclk);
        if (miss_count == 0 && pending == 0)
            $display("tb_latency_histogram_percentile OK");
        else
            $display("tb_latency_histogram_percentile NOT OK");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lhp_pkg.sv
rtl/core/lhp_queue.sv
rtl/core/lhp_front.sv
rtl/core/lhp_back.sv
rtl/core/latency_histogram_percentile.sv
rtl/core/lhp_checker.sv
sim/lhp_stats_checker.sv
sim/tb_latency_histogram_percentile.sv
